// ----- design/wbps_pkg.sv -----
// package for the wildcard byte pattern search core
// holds shared types, register indexes and constants; no dependencies
`timescale 1ns / 1ps

package wbps_pkg;

    // one byte of data or pattern
    typedef logic [7:0] t_byte;

    // register file geometry
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_WORDS  = 4;
    localparam int LEN_W      = 6;
    localparam int COUNT_W    = 32;

    // register indexes, each register sits at byte address 8*index
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_PAT_0_7   = 3'd0;
    localparam t_reg_idx REG_PAT_8_15  = 3'd1;
    localparam t_reg_idx REG_PAT_16_23 = 3'd2;
    localparam t_reg_idx REG_PAT_24_31 = 3'd3;
    localparam t_reg_idx REG_LENGTH    = 3'd4;
    localparam t_reg_idx REG_BASE      = 3'd5;

    // a pattern byte with this value matches any data byte
    localparam t_byte WILDCARD = 8'hff;

    // saturation point of the byte count
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // control from the scan sequencer to the window
    typedef struct packed {
        logic shift;   // take the byte into the window
        logic clear;   // region ends, empty the window after this byte
    } t_win_ctrl;

endpackage

// ----- design/wbps_if.sv -----
// stream interfaces of the wildcard byte pattern search core
// byte transfers in, result transfers out; depends on wbps_pkg
`timescale 1ns / 1ps

interface wbps_byte_if
    import wbps_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_result_if;
    logic        valid;
    logic        ready;
    logic        match_found;
    logic [31:0] match_offset;
    logic [63:0] match_address;

    modport source (output valid, output match_found, output match_offset,
                    output match_address, input ready);
    modport sink   (input valid, input match_found, input match_offset,
                    input match_address, output ready);
endinterface

// ----- design/wildcard_byte_pattern_search_core.sv -----
// top level of the wildcard byte pattern search core
// depends on wbps_pkg, wbps_if and wbps_window_match
`timescale 1ns / 1ps

// Scans a memory region one byte per transfer for the first occurrence of a
// pattern of up to PATTERN_BYTES bytes, where a pattern byte of 0xff matches
// any byte. Throughput is one byte per clock unless a result finds the output
// register full: a byte is taken into an input register, where the whole
// pattern is compared against the window of recent bytes in one pass, and any
// result is then loaded into the output register. The input register keeps
// accepting while a result waits to be taken; only a byte that itself
// produces a result waits on a full output register. One found result is
// given per region, on the byte that completes the match; a region (ended by
// last_byte) without a match gives one not found result. Registers sit at
// byte address 8*index on the 64-bit APB port and should be written only
// while no byte is in flight; a change in the middle of a region applies from
// the byte then held in the input register.
module wildcard_byte_pattern_search_core
    import wbps_pkg::*;
#(
    parameter int PATTERN_BYTES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wbps_byte_if.sink             i_byte,
    wbps_result_if.source         o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_BYTES);

    // configuration registers
    logic [CFG_DATA_W-1:0]           r_pat_word [PAT_WORDS];
    logic [LEN_W-1:0]                r_len;
    logic [63:0]                     r_base;
    logic [PAT_WORDS*CFG_DATA_W-1:0] w_pat_flat;
    t_reg_idx                        w_reg_idx;
    logic                            w_cfg_wr;

    // input register
    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_last;

    // region state
    logic [COUNT_W-1:0] r_seen;
    logic               r_reported;

    // output register
    logic        r_out_valid;
    logic        r_out_found;
    logic [31:0] r_out_offset;
    logic [63:0] r_out_address;

    // datapath
    logic [COUNT_W-1:0] n_seen;
    logic [COUNT_W-1:0] w_offset;
    logic [63:0]        w_address;
    logic               w_hit;
    logic               w_len_ok;
    logic               w_found;
    logic               w_res_valid;
    logic               w_out_free;
    logic               w_advance;
    t_win_ctrl          w_win_ctrl;

    // register access
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[CFG_ADDR_W-1:3];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < PAT_WORDS; w++) begin
                r_pat_word[w] <= '0;
            end
            r_len  <= '0;
            r_base <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_PAT_0_7:   r_pat_word[0] <= pwdata;
                REG_PAT_8_15:  r_pat_word[1] <= pwdata;
                REG_PAT_16_23: r_pat_word[2] <= pwdata;
                REG_PAT_24_31: r_pat_word[3] <= pwdata;
                REG_LENGTH:    r_len         <= pwdata[LEN_W-1:0];
                REG_BASE:      r_base        <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_PAT_0_7:   prdata = r_pat_word[0];
            REG_PAT_8_15:  prdata = r_pat_word[1];
            REG_PAT_16_23: prdata = r_pat_word[2];
            REG_PAT_24_31: prdata = r_pat_word[3];
            REG_LENGTH:    prdata = CFG_DATA_W'(r_len);
            REG_BASE:      prdata = r_base;
            default:       prdata = '0;
        endcase
    end

    // pattern bytes in one vector, byte 0 lowest
    always_comb begin
        for (int w = 0; w < PAT_WORDS; w++) begin
            w_pat_flat[w*CFG_DATA_W +: CFG_DATA_W] = r_pat_word[w];
        end
    end

    // window and compare
    assign w_win_ctrl.shift = w_advance;
    assign w_win_ctrl.clear = r_in_last;

    wbps_window_match #(
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_win_ctrl),
        .i_byte    (r_in_byte),
        .i_pattern (w_pat_flat[PATTERN_BYTES*8-1:0]),
        .i_length  (r_len),
        .o_hit     (w_hit)
    );

    // count, match decision and result fields
    assign n_seen      = (r_seen == COUNT_MAX) ? r_seen : r_seen + COUNT_W'(1);
    assign w_len_ok    = (r_len != '0) && (r_len <= LEN_MAX);
    assign w_found     = !r_reported && (r_base != '0) && w_len_ok
                         && (n_seen >= COUNT_W'(r_len)) && w_hit;
    assign w_offset    = n_seen - COUNT_W'(r_len);
    assign w_address   = r_base + 64'(w_offset);
    assign w_res_valid = w_found || (r_in_last && !r_reported);

    // handshake: a byte moves on unless its result finds the output full
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_advance    = r_in_valid && (!w_res_valid || w_out_free);
    assign i_byte.ready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    // region count and reported flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else if (w_advance) begin
            if (r_in_last) begin
                r_seen     <= '0;
                r_reported <= 1'b0;
            end else begin
                r_seen     <= n_seen;
                r_reported <= r_reported || w_found;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out_found   <= w_found;
            r_out_offset  <= w_found ? w_offset : '0;
            r_out_address <= w_found ? w_address : '0;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.match_found   = r_out_found;
    assign o_result.match_offset  = r_out_offset;
    assign o_result.match_address = r_out_address;

endmodule

// ----- design/wbps_window_match.sv -----
// window of the most recent bytes and the parallel wildcard compare
// depends on wbps_pkg
`timescale 1ns / 1ps

module wbps_window_match
    import wbps_pkg::*;
#(
    parameter int PATTERN_BYTES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_win_ctrl                  i_ctrl,
    input  t_byte                      i_byte,
    input  logic [PATTERN_BYTES*8-1:0] i_pattern,
    input  logic [LEN_W-1:0]           i_length,
    output logic                       o_hit
);

    localparam int IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

    t_byte            r_win [PATTERN_BYTES];
    t_byte            n_win [PATTERN_BYTES];
    t_byte            w_pat [PATTERN_BYTES];
    logic [LEN_W-1:0] w_k;
    t_byte            w_p;
    logic             w_hit;

    // split the pattern vector into bytes, byte 0 lowest
    for (genvar b = 0; b < PATTERN_BYTES; b++) begin : g_pat
        assign w_pat[b] = i_pattern[8*b +: 8];
    end

    // window after this byte, index 0 newest
    always_comb begin
        n_win[0] = i_byte;
        for (int j = 1; j < PATTERN_BYTES; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    // position j holds the pattern byte length-1-j; positions past length are free
    always_comb begin
        w_hit = 1'b1;
        w_k   = '0;
        w_p   = '0;
        for (int j = 0; j < PATTERN_BYTES; j++) begin
            if (LEN_W'(j) < i_length) begin
                w_k = i_length - LEN_W'(j) - LEN_W'(1);
                w_p = w_pat[w_k[IDX_W-1:0]];
                if (w_p != WILDCARD && w_p != n_win[j]) begin
                    w_hit = 1'b0;
                end
            end
        end
    end

    assign o_hit = w_hit;

    // window shift and region clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PATTERN_BYTES; j++) begin
                r_win[j] <= '0;
            end
        end else if (i_ctrl.shift) begin
            for (int j = 0; j < PATTERN_BYTES; j++) begin
                r_win[j] <= i_ctrl.clear ? t_byte'(0) : n_win[j];
            end
        end
    end

endmodule
